>>> rtl/core/multi_axis_step_pulse_generator_defines.svh
// Assertion macros for the step generator top module.
`ifndef MULTI_AXIS_STEP_PULSE_GENERATOR_DEFINES_SVH
`define MULTI_AXIS_STEP_PULSE_GENERATOR_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define MAPSG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define MAPSG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant checked at every edge.
`define MAPSG_ASSERT_ALW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

>>> rtl/core/mapsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mapsg_pkg;

    localparam int MAX_MOTORS_DEF = 8;
    localparam int FRAC_BITS_DEF  = 32;
    localparam int TICK_BITS_DEF  = 32;
    localparam int RATE_BITS      = 48;
    localparam int MASK_BITS      = 8;
    localparam logic [3:0] MOTOR_COUNT_RST = 4'd8;

    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_LOAD  = 3'd1,
        REQ_START = 3'd2,
        REQ_HALT  = 3'd3,
        REQ_STOP  = 3'd4
    } t_req_type;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_FIN,
        ST_RESP
    } t_state;

    // Per-cell control strobes from the sequencer.
    typedef struct packed {
        logic load;
        logic start;
        logic clear;
        logic stop;
        logic serv;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> rtl/core/mapsg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mapsg_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [2:0]  motor_index;
    logic [31:0] step_total;
    logic [32:0] start_rate;
    logic signed [31:0] accel_change;
    logic signed [31:0] decel_change;
    logic [32:0] cruise_speed;
    logic        direction;
    logic [31:0] first_event;
    logic [31:0] accel_until;
    logic [31:0] decel_after;
    logic [31:0] total_ticks;

    modport source (output valid, req_type, motor_index, step_total, start_rate,
                    accel_change, decel_change, cruise_speed, direction, first_event,
                    accel_until, decel_after, total_ticks, input ready);
    modport sink (input valid, req_type, motor_index, step_total, start_rate,
                  accel_change, decel_change, cruise_speed, direction, first_event,
                  accel_until, decel_after, total_ticks, output ready);
endinterface

interface mapsg_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] step_mask;
    logic [7:0] dir_mask;
    logic [7:0] moving_mask;
    logic       block_done;
    logic       running;

    modport source (output valid, step_mask, dir_mask, moving_mask, block_done, running,
                    input ready);
    modport sink (input valid, step_mask, dir_mask, moving_mask, block_done, running,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/mapsg_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module mapsg_cell #(
    parameter int FRAC_BITS = mapsg_pkg::FRAC_BITS_DEF,
    parameter int TICK_BITS = mapsg_pkg::TICK_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mapsg_pkg::t_cell_ctl         i_ctl,
    input  wire                          i_tok,
    input  wire  [31:0]                  i_step_total,
    input  wire  [32:0]                  i_start_rate,
    input  wire  signed [31:0]           i_accel_change,
    input  wire  signed [31:0]           i_decel_change,
    input  wire  [32:0]                  i_cruise_speed,
    input  wire                          i_direction,
    input  wire  [TICK_BITS-1:0]         i_first_event,
    input  wire  [TICK_BITS-1:0]         i_tick,
    input  wire  [TICK_BITS-1:0]         i_accel_end,
    input  wire  [TICK_BITS-1:0]         i_decel_start,
    input  wire  [TICK_BITS-1:0]         i_block_len,
    output logic                         o_tok,
    output logic                         o_step,
    output logic                         o_dir,
    output logic                         o_mov,
    output logic                         o_active
);
    localparam int RB = mapsg_pkg::RATE_BITS;
    localparam int PW = FRAC_BITS + 2;
    localparam int SW = RB + 1;
    localparam logic [PW-1:0] FP_ONE_P = PW'(1) << FRAC_BITS;
    localparam logic [SW-1:0] PH_MAX_S = {{(SW-PW){1'b0}}, {PW{1'b1}}};

    logic [31:0]          r_total, r_issued;
    logic signed [RB-1:0] r_rate, r_inc, r_dinc, r_cruise;
    logic [TICK_BITS-1:0] r_nev;
    logic [PW-1:0]        r_phase;
    logic                 r_dir, r_mov, r_force, r_b, r_do, r_tok, r_step;

    logic signed [RB:0]   w_rsum;
    logic signed [RB-1:0] n_rate, n_inc;
    logic [TICK_BITS-1:0] n_nev;
    logic                 n_force;
    logic [PW-1:0]        w_base, w_sat, w_psub;
    logic [SW-1:0]        w_psum;
    logic [31:0]          w_iss1;

    assign o_active = (r_total != 32'd0);

    // First half of a cell's turn: rate update and profile events.
    always_comb begin
        w_rsum = {r_rate[RB-1], r_rate} + {r_inc[RB-1], r_inc};
        if (w_rsum[RB] != w_rsum[RB-1]) begin
            n_rate = w_rsum[RB] ? {1'b1, {(RB-1){1'b0}}} : {1'b0, {(RB-1){1'b1}}};
        end else begin
            n_rate = w_rsum[RB-1:0];
        end
        n_inc = r_inc;
        n_nev = r_nev;
        if (i_tick == r_nev) begin
            if (i_tick == i_accel_end) begin
                n_inc = '0;
                if (i_decel_start < i_block_len) begin
                    n_nev = i_decel_start;
                    if (i_tick != i_decel_start) begin
                        n_rate = r_cruise;
                    end
                end
            end
            if (i_tick == i_decel_start) begin
                n_inc = r_dinc;
            end
        end
        n_force = n_rate[RB-1] || (n_rate == '0);
        if (n_force) begin
            n_rate = '0;
        end
    end

    // Second half: phase accumulation and step decision.
    always_comb begin
        w_base = r_force ? FP_ONE_P : r_phase;
        w_psum = {{(SW-PW){1'b0}}, w_base} + {1'b0, r_rate};
        w_sat  = (w_psum > PH_MAX_S) ? {PW{1'b1}} : w_psum[PW-1:0];
        w_psub = w_sat - FP_ONE_P;
        w_iss1 = r_issued + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_mov   <= 1'b0;
            r_dir   <= 1'b0;
            r_b     <= 1'b0;
            r_tok   <= 1'b0;
            r_step  <= 1'b0;
        end else begin
            r_tok <= r_b;
            r_b   <= i_tok;
            if (i_tok) begin
                r_step <= 1'b0;
                r_do   <= i_ctl.serv && o_active;
                if (i_ctl.serv && o_active) begin
                    r_rate  <= n_rate;
                    r_inc   <= n_inc;
                    r_nev   <= n_nev;
                    r_force <= n_force;
                end
            end
            if (r_b && r_do) begin
                if (w_sat >= FP_ONE_P) begin
                    r_phase  <= w_psub;
                    r_issued <= w_iss1;
                    r_step   <= 1'b1;
                    if (!r_mov || w_iss1 == r_total) begin
                        r_total <= '0;
                        r_mov   <= 1'b0;
                    end
                end else begin
                    r_phase <= w_sat;
                end
            end
            if (i_ctl.load) begin
                r_total  <= i_step_total;
                r_rate   <= RB'(i_start_rate);
                r_inc    <= RB'(i_accel_change);
                r_dinc   <= RB'(i_decel_change);
                r_cruise <= RB'(i_cruise_speed);
                r_dir    <= i_direction;
                r_nev    <= i_first_event;
                r_issued <= '0;
                r_phase  <= '0;
            end
            if (i_ctl.start && i_ctl.serv && o_active) begin
                r_mov <= 1'b1;
            end
            if (i_ctl.stop) begin
                r_mov <= 1'b0;
            end
            if (i_ctl.clear) begin
                r_total <= '0;
                r_mov   <= 1'b0;
            end
        end
    end

    assign o_tok  = r_tok;
    assign o_step = r_step;
    assign o_dir  = r_dir;
    assign o_mov  = r_mov;
endmodule
`default_nettype wire

>>> rtl/core/multi_axis_step_pulse_generator.sv
// A tick is accepted, then a token visits the motor cells in turn, registered in each cell,
// and the result is registered once the last cell hands the token back.
// Other items, and ticks while idle, go straight to the response state and its result register.
// One item is in flight at a time: the input is not ready until the result of the last item
// is registered; a result held by the receiver stalls the input until it is taken.
// Reset is synchronous and active low; it clears control state and motor_count returns to 8.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_axis_step_pulse_generator_defines.svh"
module multi_axis_step_pulse_generator #(
    parameter int MAX_MOTORS = mapsg_pkg::MAX_MOTORS_DEF,
    parameter int FRAC_BITS  = mapsg_pkg::FRAC_BITS_DEF,
    parameter int TICK_BITS  = mapsg_pkg::TICK_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [3:0] i_cfg_wdata,
    mapsg_req_if.sink  i_req,
    mapsg_rsp_if.source o_rsp
);
    localparam int MB = mapsg_pkg::MASK_BITS;

    mapsg_pkg::t_state    r_state, n_state;
    logic [3:0]           r_motor_count;
    logic                 r_run, n_run, r_go, n_go, r_still, n_still, r_done, n_done;
    logic [TICK_BITS-1:0] r_tick, n_tick, r_accel_end, n_accel_end;
    logic [TICK_BITS-1:0] r_decel_start, n_decel_start, r_block_len, n_block_len;
    logic [MAX_MOTORS-1:0] r_mask, n_mask;
    logic                 r_o_valid, n_o_valid;
    logic [MB-1:0]        r_o_step, n_o_step, r_o_dir, n_o_dir, r_o_mov, n_o_mov;
    logic                 r_o_done, n_o_done, r_o_run, n_o_run;

    logic [MAX_MOTORS-1:0] w_tok, w_step, w_dir, w_mov, w_act, w_serv;
    logic [MB-1:0]         w_step8, w_dir8, w_mov8;
    mapsg_pkg::t_cell_ctl  w_ctl [MAX_MOTORS];
    logic                  w_acc, w_load, w_start, w_clear, w_stop, w_idx_ok, w_any;
    logic                  w_fin_end;

    assign i_req.ready = (r_state == mapsg_pkg::ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_idx_ok    = (32'(i_req.motor_index) < MAX_MOTORS);
    assign w_any       = |(w_act & w_serv);
    assign w_fin_end   = (r_state == mapsg_pkg::ST_FIN) && !r_still;

    always_comb begin
        w_load  = 1'b0;
        w_start = 1'b0;
        w_stop  = 1'b0;
        w_clear = w_fin_end;
        if (w_acc) begin
            case (mapsg_pkg::t_req_type'(i_req.req_type))
                mapsg_pkg::REQ_LOAD:  w_load  = !r_run && w_idx_ok;
                mapsg_pkg::REQ_START: begin
                    w_start = !r_run;
                    w_clear = !r_run && !w_any;
                end
                mapsg_pkg::REQ_HALT:  w_clear = 1'b1;
                mapsg_pkg::REQ_STOP:  w_stop  = w_idx_ok;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < MAX_MOTORS; g++) begin : g_cell
        assign w_serv[g] = ({1'b0, r_motor_count} > 5'(g));
        assign w_ctl[g]  = '{
            load:  w_load && (32'(i_req.motor_index) == g),
            start: w_start,
            clear: w_clear,
            stop:  w_stop && (32'(i_req.motor_index) == g),
            serv:  w_serv[g]
        };

        mapsg_cell #(
            .FRAC_BITS (FRAC_BITS),
            .TICK_BITS (TICK_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl[g]),
            .i_tok          ((g == 0) ? r_go : w_tok[(g == 0) ? 0 : g-1]),
            .i_step_total   (i_req.step_total),
            .i_start_rate   (i_req.start_rate),
            .i_accel_change (i_req.accel_change),
            .i_decel_change (i_req.decel_change),
            .i_cruise_speed (i_req.cruise_speed),
            .i_direction    (i_req.direction),
            .i_first_event  (i_req.first_event[TICK_BITS-1:0]),
            .i_tick         (r_tick),
            .i_accel_end    (r_accel_end),
            .i_decel_start  (r_decel_start),
            .i_block_len    (r_block_len),
            .o_tok          (w_tok[g]),
            .o_step         (w_step[g]),
            .o_dir          (w_dir[g]),
            .o_mov          (w_mov[g]),
            .o_active       (w_act[g])
        );
    end

    for (genvar b = 0; b < MB; b++) begin : g_mask
        if (b < MAX_MOTORS) begin : g_on
            assign w_step8[b] = r_mask[b];
            assign w_dir8[b]  = w_dir[b];
            assign w_mov8[b]  = w_mov[b];
        end else begin : g_off
            assign w_step8[b] = 1'b0;
            assign w_dir8[b]  = 1'b0;
            assign w_mov8[b]  = 1'b0;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_run         = r_run;
        n_go          = 1'b0;
        n_still       = r_still;
        n_done        = r_done;
        n_tick        = r_tick;
        n_accel_end   = r_accel_end;
        n_decel_start = r_decel_start;
        n_block_len   = r_block_len;
        n_mask        = r_mask;
        n_o_valid     = r_o_valid && !o_rsp.ready;
        n_o_step      = r_o_step;
        n_o_dir       = r_o_dir;
        n_o_mov       = r_o_mov;
        n_o_done      = r_o_done;
        n_o_run       = r_o_run;
        case (r_state)
            mapsg_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_state = mapsg_pkg::ST_RESP;
                    n_done  = 1'b0;
                    n_mask  = '0;
                    case (mapsg_pkg::t_req_type'(i_req.req_type))
                        mapsg_pkg::REQ_TICK: begin
                            if (r_run) begin
                                n_state = mapsg_pkg::ST_TICK;
                                n_go    = 1'b1;
                            end
                        end
                        mapsg_pkg::REQ_START: begin
                            if (!r_run) begin
                                n_accel_end   = i_req.accel_until[TICK_BITS-1:0];
                                n_decel_start = i_req.decel_after[TICK_BITS-1:0];
                                n_block_len   = i_req.total_ticks[TICK_BITS-1:0];
                                n_tick        = '0;
                                n_run         = w_any;
                                n_done        = !w_any;
                            end
                        end
                        mapsg_pkg::REQ_HALT: begin
                            n_run  = 1'b0;
                            n_tick = '0;
                        end
                        default: ;
                    endcase
                end
            end
            mapsg_pkg::ST_TICK: begin
                // The last cell hands its token back once every motor has had its turn.
                if (w_tok[MAX_MOTORS-1]) begin
                    n_mask  = w_step;
                    n_still = |(w_mov & w_serv);
                    n_state = mapsg_pkg::ST_FIN;
                end
            end
            mapsg_pkg::ST_FIN: begin
                n_tick  = r_tick + TICK_BITS'(1);
                n_state = mapsg_pkg::ST_RESP;
                if (!r_still) begin
                    n_run  = 1'b0;
                    n_tick = '0;
                    n_done = 1'b1;
                end
            end
            mapsg_pkg::ST_RESP: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid = 1'b1;
                    n_o_step  = w_step8;
                    n_o_dir   = w_dir8;
                    n_o_mov   = w_mov8;
                    n_o_done  = r_done;
                    n_o_run   = r_run;
                    n_state   = mapsg_pkg::ST_IDLE;
                end
            end
            default: n_state = mapsg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mapsg_pkg::ST_IDLE;
            r_motor_count <= mapsg_pkg::MOTOR_COUNT_RST;
            r_run         <= 1'b0;
            r_go          <= 1'b0;
            r_still       <= 1'b0;
            r_done        <= 1'b0;
            r_tick        <= '0;
            r_accel_end   <= '0;
            r_decel_start <= '0;
            r_block_len   <= '0;
            r_mask        <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_run         <= n_run;
            r_go          <= n_go;
            r_still       <= n_still;
            r_done        <= n_done;
            r_tick        <= n_tick;
            r_accel_end   <= n_accel_end;
            r_decel_start <= n_decel_start;
            r_block_len   <= n_block_len;
            r_mask        <= n_mask;
            r_o_valid     <= n_o_valid;
            if (i_cfg_we) begin
                r_motor_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_step <= n_o_step;
        r_o_dir  <= n_o_dir;
        r_o_mov  <= n_o_mov;
        r_o_done <= n_o_done;
        r_o_run  <= n_o_run;
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.step_mask   = r_o_step;
    assign o_rsp.dir_mask    = r_o_dir;
    assign o_rsp.moving_mask = r_o_mov;
    assign o_rsp.block_done  = r_o_done;
    assign o_rsp.running     = r_o_run;

    `MAPSG_ASSERT_IMP(a_go_in_tick, r_go, r_state == mapsg_pkg::ST_TICK, "stray token launch")
    `MAPSG_ASSERT_ALW(a_one_token, $onehot0(w_tok), "more than one cell holds the token")
    `MAPSG_ASSERT_NXT(a_end_stops, w_fin_end, !r_run && r_done, "block end left it running")
endmodule
`default_nettype wire

>>> tb/tb_multi_axis_step_pulse_generator.sv
`timescale 1ns / 1ps
module tb_multi_axis_step_pulse_generator;

    localparam int    NMOT      = 8;
    localparam int    IDLE_PCT  = 21;
    localparam int    WD_LIMIT  = 20000;
    localparam longint RATE_MAX = (64'sd1 <<< 47) - 1;
    localparam longint RATE_MIN = -(64'sd1 <<< 47);
    localparam longint ONE_FP   = 64'sd1 <<< 32;
    localparam longint PH_MAX   = (64'sd1 <<< 34) - 1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  motor_index;
        logic [31:0] step_total;
        logic [32:0] start_rate;
        logic [31:0] accel_change;
        logic [31:0] decel_change;
        logic [32:0] cruise_speed;
        logic        direction;
        logic [31:0] first_event;
        logic [31:0] accel_until;
        logic [31:0] decel_after;
        logic [31:0] total_ticks;
    } t_req;

    typedef struct packed {
        logic [7:0] step_mask;
        logic [7:0] dir_mask;
        logic [7:0] moving_mask;
        logic       block_done;
        logic       running;
    } t_rsp;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = '0;

    mapsg_req_if req_if ();
    mapsg_rsp_if rsp_if ();

    multi_axis_step_pulse_generator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state of the step generator.
    logic [3:0]  p_motor_count;
    logic        p_run;
    logic [31:0] p_tick, p_accel_end, p_decel_start, p_length;
    logic [31:0] p_total [NMOT];
    logic [31:0] p_issued [NMOT];
    longint      p_rate [NMOT];
    longint      p_inc [NMOT];
    longint      p_dec [NMOT];
    longint      p_cruise [NMOT];
    logic [31:0] p_event [NMOT];
    longint      p_phase [NMOT];
    logic [7:0]  p_dir, p_moving;

    t_req pending_reqs [$];
    t_rsp expected_beats [$];
    int   fail_count = 0;
    bit   calm = 1'b0;          // no idling on either side
    bit   hold_sink = 1'b0;     // long receiver hold-off
    bit   req_fire = 1'b0;      // a request beat was taken at the last rising edge
    int   quiet_cycles = 0;

    function automatic int serviced_motors();
        return (p_motor_count > NMOT) ? NMOT : int'(p_motor_count);
    endfunction

    function automatic void close_block();
        p_run = 1'b0;
        p_tick = '0;
        p_moving = '0;
        for (int m = 0; m < NMOT; m++) p_total[m] = '0;
    endfunction

    function automatic void predictor_reset();
        p_motor_count = mapsg_pkg::MOTOR_COUNT_RST;
        p_run = 1'b0;
        p_tick = '0; p_accel_end = '0; p_decel_start = '0; p_length = '0;
        for (int m = 0; m < NMOT; m++) begin
            p_total[m] = '0; p_issued[m] = '0; p_rate[m] = 0; p_inc[m] = 0;
            p_dec[m] = 0; p_cruise[m] = 0; p_event[m] = '0; p_phase[m] = 0;
        end
        p_dir = '0;
        p_moving = '0;
    endfunction

    function automatic t_rsp step_motors(t_req r);
        t_rsp o;
        logic [7:0] mask;
        bit still;
        bit done;
        longint s;
        mask = '0;
        still = 0;
        done = 0;
        if (r.req_type == mapsg_pkg::REQ_TICK) begin
            if (p_run) begin
                for (int m = 0; m < serviced_motors(); m++) begin
                    if (p_total[m] == 0) continue;
                    s = p_rate[m] + p_inc[m];
                    p_rate[m] = (s > RATE_MAX) ? RATE_MAX : (s < RATE_MIN) ? RATE_MIN : s;
                    if (p_tick == p_event[m]) begin
                        if (p_tick == p_accel_end) begin
                            p_inc[m] = 0;
                            if (p_decel_start < p_length) begin
                                p_event[m] = p_decel_start;
                                if (p_tick != p_decel_start) p_rate[m] = p_cruise[m];
                            end
                        end
                        if (p_tick == p_decel_start) p_inc[m] = p_dec[m];
                    end
                    if (p_rate[m] <= 0) begin
                        p_phase[m] = ONE_FP;
                        p_rate[m] = 0;
                    end
                    p_phase[m] += p_rate[m];
                    if (p_phase[m] > PH_MAX) p_phase[m] = PH_MAX;
                    if (p_phase[m] >= ONE_FP) begin
                        p_phase[m] -= ONE_FP;
                        p_issued[m]++;
                        mask[m] = 1'b1;
                        if (!p_moving[m] || p_issued[m] == p_total[m]) begin
                            p_total[m] = '0;
                            p_moving[m] = 1'b0;
                        end
                    end
                    if (p_moving[m]) still = 1;
                end
                p_tick++;
                if (!still) begin
                    close_block();
                    done = 1;
                end
            end
        end else if (r.req_type == mapsg_pkg::REQ_LOAD) begin
            if (!p_run) begin
                p_total[r.motor_index] = r.step_total;
                p_rate[r.motor_index] = longint'({31'd0, r.start_rate});
                p_inc[r.motor_index] = longint'($signed(r.accel_change));
                p_dec[r.motor_index] = longint'($signed(r.decel_change));
                p_cruise[r.motor_index] = longint'({31'd0, r.cruise_speed});
                p_dir[r.motor_index] = r.direction;
                p_event[r.motor_index] = r.first_event;
                p_issued[r.motor_index] = '0;
                p_phase[r.motor_index] = 0;
            end
        end else if (r.req_type == mapsg_pkg::REQ_START) begin
            if (!p_run) begin
                p_accel_end = r.accel_until;
                p_decel_start = r.decel_after;
                p_length = r.total_ticks;
                p_tick = '0;
                for (int m = 0; m < serviced_motors(); m++)
                    if (p_total[m] != 0) begin
                        still = 1;
                        p_moving[m] = 1'b1;
                    end
                if (still) begin
                    p_run = 1'b1;
                end else begin
                    close_block();
                    done = 1;
                end
            end
        end else if (r.req_type == mapsg_pkg::REQ_HALT) begin
            close_block();
        end else if (r.req_type == mapsg_pkg::REQ_STOP) begin
            p_moving[r.motor_index] = 1'b0;
        end
        o.step_mask = mask;
        o.dir_mask = p_dir;
        o.moving_mask = p_moving;
        o.block_done = done;
        o.running = p_run;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        req_fire <= req_if.valid && req_if.ready;
    end

    // Driver: offers the queued items, changing at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fire) begin
            if (pending_reqs.size() > 0
                    && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                {req_if.req_type, req_if.motor_index, req_if.step_total,
                 req_if.start_rate, req_if.accel_change, req_if.decel_change,
                 req_if.cruise_speed, req_if.direction, req_if.first_event,
                 req_if.accel_until, req_if.decel_after, req_if.total_ticks}
                    <= pending_reqs.pop_front();
                req_if.valid <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver readiness.
    always @(negedge i_clk) begin
        rsp_if.ready <= !hold_sink && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: sample at the rising edge.
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        t_req r;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                r = {req_if.req_type, req_if.motor_index, req_if.step_total,
                     req_if.start_rate, req_if.accel_change, req_if.decel_change,
                     req_if.cruise_speed, req_if.direction, req_if.first_event,
                     req_if.accel_until, req_if.decel_after, req_if.total_ticks};
                expected_beats.push_back(step_motors(r));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got = {rsp_if.step_mask, rsp_if.dir_mask, rsp_if.moving_mask,
                       rsp_if.block_done, rsp_if.running};
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", got.step_mask, 8'h00);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.step_mask !== want.step_mask)
                        report_mismatch("step_mask", got.step_mask, want.step_mask);
                    if (got.dir_mask !== want.dir_mask)
                        report_mismatch("dir_mask", got.dir_mask, want.dir_mask);
                    if (got.moving_mask !== want.moving_mask)
                        report_mismatch("moving_mask", got.moving_mask, want.moving_mask);
                    if (got.block_done !== want.block_done)
                        report_mismatch("block_done", 8'(got.block_done),
                                        8'(want.block_done));
                    if (got.running !== want.running)
                        report_mismatch("running", 8'(got.running), 8'(want.running));
                end
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WD_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_req random_req();
        t_req r;
        r = '0;
        r.req_type = 3'($urandom_range(7));
        r.motor_index = 3'($urandom_range(7));
        r.step_total = $urandom;
        r.start_rate = {1'($urandom), 32'($urandom)};
        r.accel_change = $urandom;
        r.decel_change = $urandom;
        r.cruise_speed = {1'($urandom), 32'($urandom)};
        r.direction = 1'($urandom);
        r.first_event = $urandom;
        r.accel_until = $urandom;
        r.decel_after = $urandom;
        r.total_ticks = $urandom;
        return r;
    endfunction

    function automatic t_req load_req(int m, int steps, int a_end);
        t_req r;
        r = random_req();
        r.req_type = mapsg_pkg::REQ_LOAD;
        r.motor_index = 3'(m);
        r.step_total = 32'(steps);
        r.start_rate = 33'($urandom_range(32'h6000_0000));
        r.accel_change = 32'($signed($urandom_range(32'h0200_0000)) - 32'h0100_0000);
        r.decel_change = -32'($urandom_range(32'h0100_0000));
        r.cruise_speed = 33'($urandom_range(32'hC000_0000));
        r.first_event = ($urandom_range(3) == 0) ? 32'($urandom_range(12)) : 32'(a_end);
        return r;
    endfunction

    function automatic t_req tick_req(logic [2:0] kind, int m);
        t_req r;
        r = random_req();
        r.req_type = kind;
        r.motor_index = 3'(m);
        return r;
    endfunction

    // Block of loads, start and ticks, with perhaps a stop, a halt or a random item.
    task automatic queue_block();
        t_req r;
        int a_end;
        int d_start;
        a_end = $urandom_range(10);
        d_start = a_end + $urandom_range(10);
        for (int m = 0; m < NMOT; m++)
            if ($urandom_range(2) != 0) pending_reqs.push_back(load_req(m, $urandom_range(1, 12),
                                                                       a_end));
        r = tick_req(mapsg_pkg::REQ_START, 0);
        r.accel_until = 32'(a_end);
        r.decel_after = 32'(d_start);
        r.total_ticks = 32'(d_start + $urandom_range(12));
        pending_reqs.push_back(r);
        for (int t = 0; t < 30; t++) begin
            case ($urandom_range(40))
                0: pending_reqs.push_back(tick_req(mapsg_pkg::REQ_HALT, 0));
                1, 2: pending_reqs.push_back(tick_req(mapsg_pkg::REQ_STOP, $urandom_range(7)));
                3: pending_reqs.push_back(random_req());
                default: pending_reqs.push_back(tick_req(mapsg_pkg::REQ_TICK, 0));
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_if.valid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_motor_count(logic [3:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        p_motor_count = v;
    endtask

    initial begin
        t_req r;
        int hold;
        logic [3:0] counts [6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
        req_if.valid = 1'b0;
        req_if.req_type = '0; req_if.motor_index = '0; req_if.step_total = '0;
        req_if.start_rate = '0; req_if.accel_change = '0; req_if.decel_change = '0;
        req_if.cruise_speed = '0; req_if.direction = 1'b0; req_if.first_event = '0;
        req_if.accel_until = '0; req_if.decel_after = '0; req_if.total_ticks = '0;
        rsp_if.ready = 1'b0;
        predictor_reset();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle tick, empty start, extreme loads, saturation, stops, halts, odd codes.
        pending_reqs.push_back(tick_req(mapsg_pkg::REQ_TICK, 0));
        pending_reqs.push_back(tick_req(mapsg_pkg::REQ_START, 0));
        r = load_req(0, 32'hFFFF_FFFF, 0);
        r.start_rate = 33'h1_0000_0000; r.cruise_speed = 33'h1_FFFF_FFFF;
        r.accel_change = 32'h7FFF_FFFF; r.direction = 1'b1;
        pending_reqs.push_back(r);
        r = load_req(7, 2, 0);
        r.start_rate = '0; r.accel_change = 32'h8000_0000; r.decel_change = 32'h8000_0000;
        pending_reqs.push_back(r);
        r = tick_req(mapsg_pkg::REQ_START, 0);
        r.accel_until = 32'hFFFF_FFFF; r.decel_after = 32'hFFFF_FFFF;
        r.total_ticks = 32'hFFFF_FFFF;
        pending_reqs.push_back(r);
        pending_reqs.push_back(load_req(3, 5, 0));
        pending_reqs.push_back(tick_req(mapsg_pkg::REQ_START, 0));
        repeat (4) pending_reqs.push_back(tick_req(mapsg_pkg::REQ_TICK, 0));
        pending_reqs.push_back(tick_req(3'd5, 0));
        pending_reqs.push_back(tick_req(3'd7, 0));
        pending_reqs.push_back(tick_req(mapsg_pkg::REQ_STOP, 0));
        pending_reqs.push_back(tick_req(mapsg_pkg::REQ_TICK, 0));
        pending_reqs.push_back(tick_req(mapsg_pkg::REQ_STOP, 7));
        repeat (3) pending_reqs.push_back(tick_req(mapsg_pkg::REQ_TICK, 0));
        pending_reqs.push_back(tick_req(mapsg_pkg::REQ_HALT, 0));
        pending_reqs.push_back(tick_req(mapsg_pkg::REQ_HALT, 0));
        pending_reqs.push_back(tick_req(mapsg_pkg::REQ_TICK, 0));

        // Sender pauses until every result has arrived.
        wait_drained();

        calm = 1'b1;
        repeat (4) queue_block();
        // Receiver holds off while items keep coming.
        hold_sink = 1'b1;
        for (hold = 0; hold < 300; hold++) @(posedge i_clk);
        hold_sink = 1'b0;
        wait_drained();
        calm = 1'b0;

        foreach (counts[i]) begin
            write_motor_count(counts[i]);
            for (int b = 0; b < 4; b++) queue_block();
            for (int k = 0; k < 18; k++) pending_reqs.push_back(random_req());
        end
        wait_drained();

        if (fail_count == 0 && expected_beats.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mapsg_pkg.sv
rtl/core/mapsg_if.sv
rtl/core/mapsg_cell.sv
rtl/core/multi_axis_step_pulse_generator.sv
tb/tb_multi_axis_step_pulse_generator.sv
